// File: hw/rtl/ssdpm_pkg.sv
// shared types and constants for the ssd patch best match block
`default_nettype none

package ssdpm_pkg;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned SQ_W    = 2 * PIX_W;
	localparam int unsigned SUM_W   = 24;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// what the back end does with a word
	typedef enum logic [1:0] {
		KIND_ACC       = 2'd0,  // accumulate only
		KIND_PATCH_END = 2'd1,  // last pair of a candidate window
		KIND_REF_END   = 2'd2   // last pair of the last candidate, emits a result
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [SQ_W-1:0]     sq;
		logic [COORD_W-1:0]  ref_x;
		logic [COORD_W-1:0]  ref_y;
		logic [COORD_W-1:0]  cand_x;
		logic [COORD_W-1:0]  cand_y;
	} entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/ssdpm_front.sv
// front end: squared pixel difference and word classification
`default_nettype none

module ssdpm_front (
	input  wire logic [ssdpm_pkg::PIX_W-1:0]   ref_pixel,
	input  wire logic [ssdpm_pkg::PIX_W-1:0]   cand_pixel,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] ref_x,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] ref_y,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] cand_x,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] cand_y,
	input  wire logic                          patch_last,
	input  wire logic                          candidates_last,
	output ssdpm_pkg::entry_t                  entry
);

	logic [ssdpm_pkg::PIX_W-1:0] diff;

	always_comb begin
		if (ref_pixel >= cand_pixel) begin
			diff = ref_pixel - cand_pixel;
		end else begin
			diff = cand_pixel - ref_pixel;
		end
	end

	always_comb begin
		entry.sq     = ssdpm_pkg::SQ_W'(diff) * ssdpm_pkg::SQ_W'(diff);
		entry.ref_x  = ref_x;
		entry.ref_y  = ref_y;
		entry.cand_x = cand_x;
		entry.cand_y = cand_y;
		// candidates_last alone means nothing
		if (!patch_last) begin
			entry.kind = ssdpm_pkg::KIND_ACC;
		end else if (candidates_last) begin
			entry.kind = ssdpm_pkg::KIND_REF_END;
		end else begin
			entry.kind = ssdpm_pkg::KIND_PATCH_END;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssdpm_queue.sv
// small register queue between front and back end
`default_nettype none

module ssdpm_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ssdpm_pkg::entry_t wr_entry,
	input  wire logic              pop,
	output ssdpm_pkg::entry_t      rd_entry,
	output logic                   full,
	output logic                   not_empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ssdpm_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssdpm_back.sv
// back end: saturating accumulate, argmin and result register
`default_nettype none

module ssdpm_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           head_valid,
	input  wire ssdpm_pkg::entry_t              head,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [ssdpm_pkg::COORD_W-1:0]       start_x,
	output logic [ssdpm_pkg::COORD_W-1:0]       start_y,
	output logic [ssdpm_pkg::COORD_W-1:0]       end_x,
	output logic [ssdpm_pkg::COORD_W-1:0]       end_y,
	output logic [ssdpm_pkg::SUM_W-1:0]         best_score
);

	logic [ssdpm_pkg::SUM_W-1:0]   patch_sum_q;
	logic [ssdpm_pkg::SUM_W-1:0]   min_sum_q;
	logic [ssdpm_pkg::COORD_W-1:0] min_x_q;
	logic [ssdpm_pkg::COORD_W-1:0] min_y_q;
	logic                          first_q;
	logic                          out_valid_q;

	logic [ssdpm_pkg::SUM_W:0]     sum_wide;
	logic [ssdpm_pkg::SUM_W-1:0]   sum;
	logic                          take;
	logic [ssdpm_pkg::SUM_W-1:0]   new_min;
	logic [ssdpm_pkg::COORD_W-1:0] new_x;
	logic [ssdpm_pkg::COORD_W-1:0] new_y;
	logic                          out_free;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;
	// only a result-bearing word waits for the output register
	assign pop = head_valid && ((head.kind != ssdpm_pkg::KIND_REF_END) || out_free);

	always_comb begin
		sum_wide = {1'b0, patch_sum_q} + (ssdpm_pkg::SUM_W + 1)'(head.sq);
		sum      = sum_wide[ssdpm_pkg::SUM_W] ? ssdpm_pkg::SUM_MAX
		                                      : sum_wide[ssdpm_pkg::SUM_W-1:0];
		take     = first_q || (sum < min_sum_q);
		new_min  = take ? sum : min_sum_q;
		new_x    = take ? head.cand_x : min_x_q;
		new_y    = take ? head.cand_y : min_y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_sum_q <= '0;
			min_sum_q   <= ssdpm_pkg::SUM_MAX;
			min_x_q     <= '0;
			min_y_q     <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.kind)
					ssdpm_pkg::KIND_ACC: begin
						patch_sum_q <= sum;
					end
					ssdpm_pkg::KIND_PATCH_END: begin
						patch_sum_q <= '0;
						min_sum_q   <= new_min;
						min_x_q     <= new_x;
						min_y_q     <= new_y;
						first_q     <= 1'b0;
					end
					ssdpm_pkg::KIND_REF_END: begin
						patch_sum_q <= '0;
						min_sum_q   <= ssdpm_pkg::SUM_MAX;
						min_x_q     <= '0;
						min_y_q     <= '0;
						first_q     <= 1'b1;
						out_valid_q <= 1'b1;
					end
					default: begin
						patch_sum_q <= sum;
					end
				endcase
			end
		end
	end

	// result payload, loaded only when the register is free
	always_ff @(posedge clk) begin
		if (pop && (head.kind == ssdpm_pkg::KIND_REF_END)) begin
			start_x    <= head.ref_x;
			start_y    <= head.ref_y;
			end_x      <= new_x;
			end_y      <= new_y;
			best_score <= new_min;
		end
	end

	a_ref_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (head.kind == ssdpm_pkg::KIND_REF_END) |=> out_valid_q)
		else $error("result word not raised after last candidate");

	a_ref_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (head.kind == ssdpm_pkg::KIND_REF_END)
		|=> first_q && (min_sum_q == ssdpm_pkg::SUM_MAX) && (patch_sum_q == '0))
		else $error("reference state not cleared after result");

	a_patch_end_taken: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (head.kind == ssdpm_pkg::KIND_PATCH_END) |=> !first_q && (patch_sum_q == '0))
		else $error("candidate end did not record a best match");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(pop && (head.kind == ssdpm_pkg::KIND_REF_END)))
		else $error("stalled result word overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/ssd_patch_best_match.sv
// top level of the ssd patch best match block
`default_nettype none

// channel   direction  handshake               payload
// in        sink       in_valid / in_stall     ref_pixel, cand_pixel, ref_x, ref_y,
//                                              cand_x, cand_y, patch_last, candidates_last
// out       source     out_valid / out_stall   start_x, start_y, end_x, end_y, best_score
//
// one input word per cycle sustained while the queue is not full; the single squarer in the
// front end and the saturating accumulate in the back end each handle one pixel pair a cycle
// with an empty queue, the last pixel pair of the last candidate is written to the queue and
// then popped into the result register, where out_valid rises; queued words ahead of it delay it
// reset is asynchronous, active low; no clearing pass, the block takes words at once
// out_stall holds only a result-bearing word at the queue head; the queue of
// QUEUE_DEPTH words absorbs input meanwhile and in_stall rises only when it is full

module ssd_patch_best_match #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [ssdpm_pkg::PIX_W-1:0]   ref_pixel,
	input  wire logic [ssdpm_pkg::PIX_W-1:0]   cand_pixel,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] ref_x,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] ref_y,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] cand_x,
	input  wire logic [ssdpm_pkg::COORD_W-1:0] cand_y,
	input  wire logic                          patch_last,
	input  wire logic                          candidates_last,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [ssdpm_pkg::COORD_W-1:0]      start_x,
	output logic [ssdpm_pkg::COORD_W-1:0]      start_y,
	output logic [ssdpm_pkg::COORD_W-1:0]      end_x,
	output logic [ssdpm_pkg::COORD_W-1:0]      end_y,
	output logic [ssdpm_pkg::SUM_W-1:0]        best_score
);

	ssdpm_pkg::entry_t front_entry;  // classified word from the front end
	ssdpm_pkg::entry_t head_entry;   // oldest queued word
	logic              q_full;
	logic              q_not_empty;
	logic              q_push;
	logic              q_pop;

	// stall depends on queue occupancy only, never on in_valid
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	ssdpm_front u_front (
		.ref_pixel       (ref_pixel),
		.cand_pixel      (cand_pixel),
		.ref_x           (ref_x),
		.ref_y           (ref_y),
		.cand_x          (cand_x),
		.cand_y          (cand_y),
		.patch_last      (patch_last),
		.candidates_last (candidates_last),
		.entry           (front_entry)
	);

	ssdpm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (front_entry),
		.pop       (q_pop),
		.rd_entry  (head_entry),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// back end keeps running sum, best match and the result register
	ssdpm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (head_entry),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.best_score (best_score)
	);

endmodule

`default_nettype wire
